@@ sv/random_texture_pixel_generator_macros.svh @@
// Assertion macros used by the random texture pixel generator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef RANDOM_TEXTURE_PIXEL_GENERATOR_MACROS_SVH
`define RANDOM_TEXTURE_PIXEL_GENERATOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while in reset
`define RTPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtpg assertion failed");
// Next-cycle implication, disabled while in reset
`define RTPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtpg assertion failed");
`else
`define RTPG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RTPG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/rtpg_pkg.sv @@
// Shared types and constants of the random texture pixel generator.
// Used by the controller, the datapath and the top level; depends on nothing.
package rtpg_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_GENERATE    = 2'd0,
        CMD_WRITE_CDF   = 2'd1,
        CMD_WRITE_COLOR = 2'd2,
        CMD_LOAD_SEED   = 2'd3
    } t_cmd_code;

    // Configuration register indexes
    localparam logic [1:0] CFG_TABLE_LENGTH = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int TLEN_W      = 9;
    localparam int DIM_W       = 13;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int ENTRY_W  = 8;
    localparam int LOAD_W   = 48;
    localparam int BYTE_W   = 8;
    localparam int DRAW_W   = 32;
    localparam int COLOR_W  = 24;
    localparam int PIX_W    = 12;

    // Generator constants
    localparam int             STATE_W   = 48;
    localparam int             CHUNK_W   = 16;
    localparam logic [34:0]    LCG_MUL   = 35'h5_DEEC_E66D;
    localparam logic [47:0]    LCG_ADD   = 48'h0000_0000_000B;
    localparam logic [1:0]     LCG_LAST  = 2'd2;
    localparam logic [31:0]    DRAW_FLIP = 32'h8000_0000;
    localparam logic [7:0]     ALPHA_FULL = 8'hFF;

    // Controller to datapath commands
    typedef struct packed {
        logic       gen_start;   // init accumulator and search bounds
        logic       lcg_step;    // accumulate one partial product
        logic [1:0] lcg_chunk;   // which 16-bit state chunk
        logic       probe;       // compute mid, issue table read
        logic       compare;     // narrow the search bounds
        logic       emit;        // load the output register, advance raster
        logic       cdf_we;      // write cdf entry from payload
        logic       color_we;    // write colour entry from payload
        logic       seed_load;   // load generator state from payload
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic search_done;       // bisection has converged this probe
        logic out_free;          // output register can take a result
    } t_dp_status;

endpackage

@@ sv/rtpg_ram.sv @@
// Generic simple dual-port RAM with registered read.
// Depends on nothing; used for the cdf and colour tables.
module rtpg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/rtpg_ctrl.sv @@
// Controller state machine of the random texture pixel generator.
// Depends on rtpg_pkg; drives datapath commands from its status.
module rtpg_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rtpg_pkg::CMD_W-1:0]    i_cmd,
    input  rtpg_pkg::t_dp_status          i_status,
    output rtpg_pkg::t_dp_cmd             o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LCG,
        S_PROBE,
        S_CMP,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       r_in_ready, n_in_ready;
    logic       accept;

    assign accept = i_in_valid && r_in_ready;

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_in_ready = r_in_ready;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (rtpg_pkg::t_cmd_code'(i_cmd))
                        rtpg_pkg::CMD_GENERATE: begin
                            o_cmd.gen_start = 1'b1;
                            n_state         = S_LCG;
                            n_step          = '0;
                            n_in_ready      = 1'b0;
                        end
                        rtpg_pkg::CMD_WRITE_CDF:   o_cmd.cdf_we    = 1'b1;
                        rtpg_pkg::CMD_WRITE_COLOR: o_cmd.color_we  = 1'b1;
                        rtpg_pkg::CMD_LOAD_SEED:   o_cmd.seed_load = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_LCG: begin
                o_cmd.lcg_step  = 1'b1;
                o_cmd.lcg_chunk = r_step;
                if (r_step == rtpg_pkg::LCG_LAST) begin
                    n_state = S_PROBE;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                n_state     = i_status.search_done ? S_EMIT : S_CMP;
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_PROBE;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    n_in_ready = 1'b1;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_ready = 1'b1;
            end
        endcase
    end

    // Hold state, step count and ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

@@ sv/rtpg_dp.sv @@
// Datapath of the random texture pixel generator: generator, tables,
// bisection, raster counters, configuration and output register.
// Depends on rtpg_pkg, rtpg_ram and the assertion macros.
`include "random_texture_pixel_generator_macros.svh"

module rtpg_dp #(
    parameter int TABLE_DEPTH   = 256,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rtpg_pkg::t_dp_cmd                  i_cmd,
    output rtpg_pkg::t_dp_status               o_status,
    input  logic [rtpg_pkg::ENTRY_W-1:0]       i_entry_index,
    input  logic [rtpg_pkg::LOAD_W-1:0]        i_load_value,
    input  logic                               i_cfg_we,
    input  logic [rtpg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [rtpg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [rtpg_pkg::BYTE_W-1:0]        o_red,
    output logic [rtpg_pkg::BYTE_W-1:0]        o_green,
    output logic [rtpg_pkg::BYTE_W-1:0]        o_blue,
    output logic [rtpg_pkg::BYTE_W-1:0]        o_alpha,
    output logic [rtpg_pkg::ENTRY_W-1:0]       o_color_index,
    output logic [rtpg_pkg::DRAW_W-1:0]        o_uniform_draw,
    output logic [rtpg_pkg::PIX_W-1:0]         o_pixel_x,
    output logic [rtpg_pkg::PIX_W-1:0]         o_pixel_y,
    output logic                               o_last_of_frame
);

    // Table index widths
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int TDW  = $clog2(TABLE_DEPTH + 1);
    localparam int LW   = (TDW > rtpg_pkg::TLEN_W) ? TDW : rtpg_pkg::TLEN_W;
    localparam int EW   = (TDW > rtpg_pkg::ENTRY_W) ? TDW : rtpg_pkg::ENTRY_W;
    localparam int AW   = (IW > rtpg_pkg::ENTRY_W) ? IW : rtpg_pkg::ENTRY_W;
    // Raster counter widths
    localparam int DW   = $clog2(MAX_DIMENSION);
    localparam int CW   = (DW + 1 > rtpg_pkg::DIM_W) ? DW + 1 : rtpg_pkg::DIM_W;
    localparam int XW   = (DW > rtpg_pkg::PIX_W) ? DW : rtpg_pkg::PIX_W;

    // Configuration registers
    logic [rtpg_pkg::TLEN_W-1:0] r_cfg_len;
    logic [rtpg_pkg::DIM_W-1:0]  r_cfg_width;
    logic [rtpg_pkg::DIM_W-1:0]  r_cfg_height;

    // Generator
    logic [rtpg_pkg::STATE_W-1:0] r_gen_state;
    logic [rtpg_pkg::STATE_W-1:0] r_acc;
    logic [rtpg_pkg::CHUNK_W-1:0] chunk;
    logic [50:0]                  prod;
    logic [rtpg_pkg::STATE_W-1:0] part;
    logic [rtpg_pkg::STATE_W-1:0] acc_next;
    logic [rtpg_pkg::DRAW_W-1:0]  draw;

    // Search
    logic [IW-1:0] r_lo, r_hi, r_mid;
    logic [IW-1:0] mid;
    logic [IW-1:0] span;
    logic [LW-1:0] len_raw, len_eff;
    logic          search_done;

    // Tables
    logic [EW-1:0]                 entry_ext;
    logic [AW-1:0]                 waddr_ext;
    logic                          entry_ok;
    logic [rtpg_pkg::DRAW_W-1:0]   cdf_rdata;
    logic [rtpg_pkg::COLOR_W-1:0]  color_rdata;

    // Raster
    logic [DW-1:0] r_col, r_row;
    logic [CW-1:0] w_raw, h_raw, w_eff, h_eff, col_cmp, row_cmp;
    logic          last_col, last_row;
    logic [XW-1:0] col_ext, row_ext;
    logic [AW-1:0] sel_ext;

    // Output register
    logic                          r_out_valid;
    logic [rtpg_pkg::COLOR_W-1:0]  r_rgb;
    logic [rtpg_pkg::ENTRY_W-1:0]  r_index;
    logic [rtpg_pkg::DRAW_W-1:0]   r_draw;
    logic [rtpg_pkg::PIX_W-1:0]    r_px, r_py;
    logic                          r_last;
    logic                          out_free;

    // Latch configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len    <= rtpg_pkg::TLEN_W'(1);
            r_cfg_width  <= rtpg_pkg::DIM_W'(1);
            r_cfg_height <= rtpg_pkg::DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtpg_pkg::CFG_TABLE_LENGTH: r_cfg_len    <= i_cfg_data[rtpg_pkg::TLEN_W-1:0];
                rtpg_pkg::CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                rtpg_pkg::CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Select one 16-bit chunk of the state and weigh it by the multiplier
    always_comb begin
        case (i_cmd.lcg_chunk)
            2'd0:    chunk = r_gen_state[15:0];
            2'd1:    chunk = r_gen_state[31:16];
            default: chunk = r_gen_state[47:32];
        endcase
        prod = 51'(chunk) * 51'(rtpg_pkg::LCG_MUL);
        case (i_cmd.lcg_chunk)
            2'd0:    part = prod[47:0];
            2'd1:    part = {prod[31:0], 16'h0000};
            default: part = {prod[15:0], 32'h0000_0000};
        endcase
        acc_next = r_acc + part;
    end

    // Advance the generator over three partial products, or load a seed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_state <= '0;
        end else if (i_cmd.seed_load) begin
            r_gen_state <= i_load_value;
        end else if (i_cmd.lcg_step && i_cmd.lcg_chunk == rtpg_pkg::LCG_LAST) begin
            r_gen_state <= acc_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_start) begin
            r_acc <= rtpg_pkg::LCG_ADD;
        end else if (i_cmd.lcg_step) begin
            r_acc <= acc_next;
        end
    end

    assign draw = r_gen_state[47:16] ^ rtpg_pkg::DRAW_FLIP;

    // Clamp the table length into 1..TABLE_DEPTH
    assign len_raw = LW'(r_cfg_len);
    assign len_eff = (len_raw == '0) ? LW'(1) :
                     (len_raw > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : len_raw;

    // Bisection midpoint
    assign span        = r_hi - r_lo;
    assign mid         = r_lo + (span >> 1);
    assign search_done = (mid == r_lo);

    // Update the search bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_start) begin
            r_lo <= '0;
            r_hi <= IW'(len_eff - LW'(1));
        end else if (i_cmd.probe) begin
            r_mid <= mid;
        end else if (i_cmd.compare) begin
            if (cdf_rdata > draw) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid;
            end
        end
    end

    // Table write address and range check
    assign entry_ext = EW'(i_entry_index);
    assign entry_ok  = entry_ext < EW'(TABLE_DEPTH);
    assign waddr_ext = AW'(i_entry_index);

    rtpg_ram #(
        .WIDTH (rtpg_pkg::DRAW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_cdf_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cdf_we && entry_ok),
        .i_waddr (waddr_ext[IW-1:0]),
        .i_wdata (i_load_value[rtpg_pkg::DRAW_W-1:0]),
        .i_re    (i_cmd.probe && !search_done),
        .i_raddr (mid),
        .o_rdata (cdf_rdata)
    );

    rtpg_ram #(
        .WIDTH (rtpg_pkg::COLOR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.color_we && entry_ok),
        .i_waddr (waddr_ext[IW-1:0]),
        .i_wdata (i_load_value[rtpg_pkg::COLOR_W-1:0]),
        .i_re    (i_cmd.probe && search_done),
        .i_raddr (r_hi),
        .o_rdata (color_rdata)
    );

    // Clamp the frame size and find the last column and row
    assign w_raw   = CW'(r_cfg_width);
    assign h_raw   = CW'(r_cfg_height);
    assign w_eff   = (w_raw == '0) ? CW'(1) :
                     (w_raw > CW'(MAX_DIMENSION)) ? CW'(MAX_DIMENSION) : w_raw;
    assign h_eff   = (h_raw == '0) ? CW'(1) :
                     (h_raw > CW'(MAX_DIMENSION)) ? CW'(MAX_DIMENSION) : h_raw;
    assign col_cmp = CW'(r_col);
    assign row_cmp = CW'(r_row);
    assign last_col = col_cmp >= (w_eff - CW'(1));
    assign last_row = row_cmp >= (h_eff - CW'(1));

    // Advance the raster position on each emitted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.emit) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + DW'(1);
            end else begin
                r_col <= r_col + DW'(1);
            end
        end
    end

    assign col_ext = XW'(r_col);
    assign row_ext = XW'(r_row);
    assign sel_ext = AW'(r_hi);

    // Output register: load on emit, drop on transfer
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_rgb   <= color_rdata;
            r_index <= sel_ext[rtpg_pkg::ENTRY_W-1:0];
            r_draw  <= draw;
            r_px    <= col_ext[rtpg_pkg::PIX_W-1:0];
            r_py    <= row_ext[rtpg_pkg::PIX_W-1:0];
            r_last  <= last_col && last_row;
        end
    end

    assign o_status.search_done = search_done;
    assign o_status.out_free    = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_red           = r_rgb[23:16];
    assign o_green         = r_rgb[15:8];
    assign o_blue          = r_rgb[7:0];
    assign o_alpha         = rtpg_pkg::ALPHA_FULL;
    assign o_color_index   = r_index;
    assign o_uniform_draw  = r_draw;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_last_of_frame = r_last;

    // Search bounds stay ordered, each compare narrows them,
    // and a result is only loaded into a free output register
    `RTPG_ASSERT_IMP(a_bounds_ordered, i_clk, i_rst_n, i_cmd.probe, r_lo <= r_hi)
    `RTPG_ASSERT_NXT(a_compare_narrows, i_clk, i_rst_n, i_cmd.compare, span < $past(span))
    `RTPG_ASSERT_IMP(a_emit_when_free, i_clk, i_rst_n, i_cmd.emit, out_free)

endmodule

@@ sv/random_texture_pixel_generator.sv @@
// Random texture pixel generator. Each generate transfer steps a 48-bit
// linear congruential generator, turns bits 47:16 into a 0.32 uniform draw,
// bisects the loaded cdf table for it and emits the chosen colour entry as an
// RGBA pixel (alpha 255) with its raster position. Table writes and seed
// loads are applied as they are taken in and produce no result. A generate
// transfer occupies the block until its pixel is loaded: three partial
// products on the shared 16x35 multiplier, then a probe and a compare on the
// single registered cdf read port for each bisection compare (about log2 of
// table_length compares, 8 for a full 256-entry table), a final probe that
// reads the colour, and the load of the output register once it is free. A
// finished pixel waits in the output register while the next item is taken
// in. Table entries must be written before a search can reach them. Depends
// on rtpg_pkg, rtpg_ctrl and rtpg_dp.
module random_texture_pixel_generator #(
    parameter int TABLE_DEPTH   = 256,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [rtpg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [rtpg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [rtpg_pkg::CMD_W-1:0]         i_cmd,
    input  logic [rtpg_pkg::ENTRY_W-1:0]       i_entry_index,
    input  logic [rtpg_pkg::LOAD_W-1:0]        i_load_value,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [rtpg_pkg::BYTE_W-1:0]        o_red,
    output logic [rtpg_pkg::BYTE_W-1:0]        o_green,
    output logic [rtpg_pkg::BYTE_W-1:0]        o_blue,
    output logic [rtpg_pkg::BYTE_W-1:0]        o_alpha,
    output logic [rtpg_pkg::ENTRY_W-1:0]       o_color_index,
    output logic [rtpg_pkg::DRAW_W-1:0]        o_uniform_draw,
    output logic [rtpg_pkg::PIX_W-1:0]         o_pixel_x,
    output logic [rtpg_pkg::PIX_W-1:0]         o_pixel_y,
    output logic                               o_last_of_frame
);

    rtpg_pkg::t_dp_cmd    dp_cmd;
    rtpg_pkg::t_dp_status dp_status;

    rtpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    rtpg_dp #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_entry_index   (i_entry_index),
        .i_load_value    (i_load_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_alpha         (o_alpha),
        .o_color_index   (o_color_index),
        .o_uniform_draw  (o_uniform_draw),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

@@ tb/sv/tb_random_texture_pixel_generator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for random_texture_pixel_generator: it predicts each pixel
// and compares every transfer on the output channel. Depends on rtpg_pkg and the RTL.
module tb_random_texture_pixel_generator;

    localparam int          TABLE_DEPTH   = 256;
    localparam int          MAX_DIM       = 4096;
    localparam logic [47:0] GEN_MUL       = 48'h0005_DEEC_E66D;
    localparam logic [47:0] GEN_INC       = 48'h0000_0000_000B;
    localparam logic [31:0] HALF_FLIP     = 32'h8000_0000;
    localparam int          IDLE_PCT      = 18;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 600000;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  color_index;
        logic [31:0] uniform_draw;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic        last_of_frame;
    } t_pixel;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [rtpg_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [rtpg_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic [rtpg_pkg::CMD_W-1:0]       i_cmd;
    logic [rtpg_pkg::ENTRY_W-1:0]     i_entry_index;
    logic [rtpg_pkg::LOAD_W-1:0]      i_load_value;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [rtpg_pkg::BYTE_W-1:0]      o_red;
    logic [rtpg_pkg::BYTE_W-1:0]      o_green;
    logic [rtpg_pkg::BYTE_W-1:0]      o_blue;
    logic [rtpg_pkg::BYTE_W-1:0]      o_alpha;
    logic [rtpg_pkg::ENTRY_W-1:0]     o_color_index;
    logic [rtpg_pkg::DRAW_W-1:0]      o_uniform_draw;
    logic [rtpg_pkg::PIX_W-1:0]       o_pixel_x;
    logic [rtpg_pkg::PIX_W-1:0]       o_pixel_y;
    logic                             o_last_of_frame;

    // Predictor state: generator, tables, raster counters and register copies
    logic [47:0] lcg_state;
    logic [31:0] cdf_mem [TABLE_DEPTH];
    logic [23:0] color_mem [TABLE_DEPTH];
    int          col_cnt;
    int          row_cnt;
    logic [8:0]  tlen_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    t_pixel      pixel_expect_q [$];

    bit src_idle_on;
    bit snk_idle_on;
    int mismatch_count;
    int cycle_count;

    random_texture_pixel_generator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_entry_index   (i_entry_index),
        .i_load_value    (i_load_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_alpha         (o_alpha),
        .o_color_index   (o_color_index),
        .o_uniform_draw  (o_uniform_draw),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_frame (o_last_of_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("random_texture_pixel_generator: mismatch");
            $finish;
        end
    end

    // Stall the output channel at random
    always @(negedge i_clk) begin
        i_out_ready <= !(snk_idle_on && $urandom_range(99) < IDLE_PCT);
    end

    function automatic int clamp_to(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Bisect the cdf table; the upper bound is the answer, so entry 0 is never taken
    // unless the table holds a single entry
    function automatic int bisect_cdf(logic [31:0] draw, int len);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = len - 1;
        mid = lo + (hi - lo) / 2;
        while (mid != lo) begin
            if (cdf_mem[mid] > draw) hi = mid;
            else lo = mid;
            mid = lo + (hi - lo) / 2;
        end
        return hi;
    endfunction

    // Apply one accepted command to the predictor; a generate queues its pixel
    function automatic void apply_texture_command(rtpg_pkg::t_cmd_code cmd, logic [7:0] idx,
                                                  logic [47:0] val);
        t_pixel      px;
        logic [31:0] draw;
        logic [23:0] rgb;
        int          sel;
        int          w;
        int          h;
        bit          last_col;
        bit          last_row;
        case (cmd)
            rtpg_pkg::CMD_WRITE_CDF:   cdf_mem[idx] = val[31:0];
            rtpg_pkg::CMD_WRITE_COLOR: color_mem[idx] = val[23:0];
            rtpg_pkg::CMD_LOAD_SEED:   lcg_state = val;
            default: begin
                lcg_state = lcg_state * GEN_MUL + GEN_INC;
                draw      = lcg_state[47:16] ^ HALF_FLIP;
                sel       = bisect_cdf(draw, clamp_to(int'(tlen_reg), TABLE_DEPTH));
                rgb       = color_mem[sel];
                w         = clamp_to(int'(width_reg), MAX_DIM);
                h         = clamp_to(int'(height_reg), MAX_DIM);
                last_col  = col_cnt >= w - 1;
                last_row  = row_cnt >= h - 1;
                px.red           = rgb[23:16];
                px.green         = rgb[15:8];
                px.blue          = rgb[7:0];
                px.alpha         = 8'hFF;
                px.color_index   = 8'(sel);
                px.uniform_draw  = draw;
                px.pixel_x       = 12'(col_cnt);
                px.pixel_y       = 12'(row_cnt);
                px.last_of_frame = last_col && last_row;
                pixel_expect_q.push_back(px);
                // Advance the raster position
                if (last_col) begin
                    col_cnt = 0;
                    row_cnt = last_row ? 0 : row_cnt + 1;
                end else begin
                    col_cnt = col_cnt + 1;
                end
            end
        endcase
    endfunction

    function automatic void compare_field(string label, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    // Check each output transfer against the oldest predicted pixel
    always @(posedge i_clk) begin : pixel_check
        t_pixel px;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_expect_q.size() == 0) begin
                $display("%0t ns: pixel transfer with none expected, draw 0x%0h",
                         $time, o_uniform_draw);
                mismatch_count++;
            end else begin
                px = pixel_expect_q.pop_front();
                compare_field("red", px.red, o_red);
                compare_field("green", px.green, o_green);
                compare_field("blue", px.blue, o_blue);
                compare_field("alpha", px.alpha, o_alpha);
                compare_field("color_index", px.color_index, o_color_index);
                compare_field("uniform_draw", px.uniform_draw, o_uniform_draw);
                compare_field("pixel_x", px.pixel_x, o_pixel_x);
                compare_field("pixel_y", px.pixel_y, o_pixel_y);
                compare_field("last_of_frame", px.last_of_frame, o_last_of_frame);
            end
        end
    end

    function automatic logic [47:0] random_wide();
        return 48'({$urandom, $urandom});
    endfunction

    // Present one item and hold it until the transfer
    task automatic send_item(rtpg_pkg::t_cmd_code cmd, logic [7:0] idx, logic [47:0] val);
        @(negedge i_clk);
        while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_entry_index <= idx;
        i_load_value  <= val;
        do @(posedge i_clk); while (!o_in_ready);
        apply_texture_command(cmd, idx, val);
    endtask

    // Hold the input channel until every pixel is out and the block has settled
    task automatic wait_for_pixels_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pixel_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [12:0] data);
        @(negedge i_clk);
        i_in_valid  <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            rtpg_pkg::CFG_TABLE_LENGTH: tlen_reg = data[8:0];
            rtpg_pkg::CFG_IMAGE_WIDTH:  width_reg = data;
            rtpg_pkg::CFG_IMAGE_HEIGHT: height_reg = data;
            default: ;
        endcase
    endtask

    task automatic set_frame(logic [12:0] tlen, logic [12:0] w, logic [12:0] h);
        wait_for_pixels_drained();
        write_register(rtpg_pkg::CFG_TABLE_LENGTH, tlen);
        write_register(rtpg_pkg::CFG_IMAGE_WIDTH, w);
        write_register(rtpg_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic generate_pixels(int n);
        repeat (n) send_item(rtpg_pkg::CMD_GENERATE, 8'($urandom), random_wide());
    endtask

    // Load an ascending cdf over the entries in use, with random spacing
    task automatic load_sorted_cdf(int len);
        longint base;
        longint step;
        step = (longint'(1) << 32) / len;
        for (int i = 1; i < len; i++) begin
            base = longint'(i) * step + longint'($urandom) % (step / 2 + 1);
            send_item(rtpg_pkg::CMD_WRITE_CDF, 8'(i), {16'($urandom), 32'(base)});
        end
    endtask

    // After reset: one-entry table, 1x1 frame, generator at zero
    task automatic test_reset_state();
        send_item(rtpg_pkg::CMD_WRITE_COLOR, 8'd0, 48'hFFFF_FF12_3456);
        generate_pixels(3);
    endtask

    task automatic test_seed_extremes();
        send_item(rtpg_pkg::CMD_LOAD_SEED, 8'hFF, 48'hFFFF_FFFF_FFFF);
        generate_pixels(2);
        send_item(rtpg_pkg::CMD_LOAD_SEED, 8'h00, 48'h0);
        generate_pixels(1);
        send_item(rtpg_pkg::CMD_LOAD_SEED, 8'h5A, random_wide());
        generate_pixels(1);
    endtask

    // Write every entry of both tables so that no search reads an unwritten one
    task automatic test_fill_tables();
        logic [31:0] thr;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == 1) thr = 32'h0;
            else if (i == TABLE_DEPTH - 1) thr = 32'hFFFF_FFFF;
            else thr = {8'(i), 24'($urandom)};
            send_item(rtpg_pkg::CMD_WRITE_CDF, 8'(i), {16'($urandom), thr});
            send_item(rtpg_pkg::CMD_WRITE_COLOR, 8'(i), random_wide());
        end
    endtask

    // Zero, full and oversized table lengths, and bits above the register width
    task automatic test_table_length_limits();
        set_frame(13'd256, 13'd4, 13'd4);
        generate_pixels(3);
        set_frame(13'd0, 13'd4, 13'd4);
        generate_pixels(2);
        set_frame(13'h1FFF, 13'd4, 13'd4);
        generate_pixels(2);
        set_frame(13'h1E02, 13'd4, 13'd4);
        generate_pixels(2);
    endtask

    // Shrink the frame under the counters, then zero and oversized sizes
    task automatic test_shrunken_frame();
        set_frame(13'd256, 13'd4096, 13'd4096);
        generate_pixels(12);
        set_frame(13'd256, 13'd5, 13'd1);
        generate_pixels(8);
        set_frame(13'd256, 13'd40, 13'd30);
        generate_pixels(45);
        set_frame(13'd256, 13'd3, 13'd0);
        generate_pixels(4);
        set_frame(13'd256, 13'h1FFF, 13'h1FFF);
        generate_pixels(3);
    endtask

    // Mostly generates with random table rewrites and reseeds, some full pauses
    task automatic test_random_phase(logic [12:0] tlen, logic [12:0] w, logic [12:0] h,
                                     int n_items, bit src_idle, bit snk_idle, bit sorted);
        int pick;
        set_frame(tlen, w, h);
        src_idle_on = src_idle;
        snk_idle_on = snk_idle;
        if (sorted) load_sorted_cdf(clamp_to(int'(tlen[8:0]), TABLE_DEPTH));
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) send_item(rtpg_pkg::CMD_GENERATE, 8'($urandom), random_wide());
            else if (pick < 80) send_item(rtpg_pkg::CMD_WRITE_CDF, 8'($urandom), random_wide());
            else if (pick < 89) send_item(rtpg_pkg::CMD_WRITE_COLOR, 8'($urandom), random_wide());
            else if (pick < 98) send_item(rtpg_pkg::CMD_LOAD_SEED, 8'($urandom), random_wide());
            else wait_for_pixels_drained();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_cmd          = '0;
        i_entry_index  = '0;
        i_load_value   = '0;
        src_idle_on    = 1'b1;
        snk_idle_on    = 1'b1;
        lcg_state      = '0;
        col_cnt        = 0;
        row_cnt        = 0;
        tlen_reg       = 9'd1;
        width_reg      = 13'd1;
        height_reg     = 13'd1;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_seed_extremes();
        test_fill_tables();
        test_table_length_limits();
        test_shrunken_frame();
        test_random_phase(13'd4, 13'd8, 13'd3, 80, 1'b1, 1'b1, 1'b1);
        test_random_phase(13'd256, 13'd16, 13'd16, 120, 1'b0, 1'b0, 1'b1);
        test_random_phase(13'd2, 13'd1, 13'd5, 60, 1'b1, 1'b1, 1'b0);
        test_random_phase(13'd37, 13'd4096, 13'd2, 80, 1'b1, 1'b0, 1'b1);
        test_random_phase(13'd100, 13'd7, 13'd1, 80, 1'b0, 1'b1, 1'b0);
        test_random_phase(13'd256, 13'd3, 13'd4096, 80, 1'b1, 1'b1, 1'b0);
        test_random_phase(13'd0, 13'd2, 13'd2, 60, 1'b1, 1'b1, 1'b0);
        test_random_phase(13'h1FFF, 13'd1, 13'd1, 60, 1'b1, 1'b1, 1'b1);
        test_random_phase(13'd9, 13'd0, 13'd6, 60, 1'b1, 1'b1, 1'b1);
        wait_for_pixels_drained();

        if (mismatch_count == 0) begin
            $display("random_texture_pixel_generator: match");
        end else begin
            $display("random_texture_pixel_generator: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/rtpg_pkg.sv
sv/rtpg_ram.sv
sv/rtpg_ctrl.sv
sv/rtpg_dp.sv
sv/random_texture_pixel_generator.sv
tb/sv/tb_random_texture_pixel_generator.sv
